[hw/rtl/radar_sentence_parser_defines.svh]
// Assertion helpers for the parser's modules; only rsp_back uses them.
`ifndef RADAR_SENTENCE_PARSER_DEFINES_SVH
`define RADAR_SENTENCE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define RSP_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rsp assertion failed");
`define RSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rsp assertion failed");
`else
`define RSP_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define RSP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/rsp_pkg.sv]
package rsp_pkg;

    localparam int PART_W = 4;
    localparam int INT_W  = 33;

    // operation carried by a queued word
    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // character classes seen by the field parser
    localparam logic [2:0] CC_OTHER = 3'd0;
    localparam logic [2:0] CC_COMMA = 3'd1;
    localparam logic [2:0] CC_DIGIT = 3'd2;
    localparam logic [2:0] CC_PLUS  = 3'd3;
    localparam logic [2:0] CC_MINUS = 3'd4;
    localparam logic [2:0] CC_POINT = 3'd5;
    localparam logic [2:0] CC_SPACE = 3'd6;

    localparam logic [1:0] KIND_UNKNOWN  = 2'd0;
    localparam logic [1:0] KIND_PRESENCE = 2'd1;
    localparam logic [1:0] KIND_SPEED    = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } in_t;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic               target_present;
        logic               fields_valid;
        logic [7:0]         target_count;
        logic [15:0]        range_cm;
        logic signed [15:0] speed_cm_per_s;
        logic [31:0]        energy_value;
    } out_t;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] cls;
        logic [3:0] dig;
        logic       closes;
        logic [1:0] kind;
        logic       present;
    } event_t;

endpackage

[hw/rtl/rsp_queue.sv]
module rsp_queue
    import rsp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  event_t push_data,
    output logic   full,
    input  logic   pop,
    output event_t pop_data,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    event_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/rsp_front.sv]
module rsp_front
    import rsp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  in_t    s_data,
    input  logic   q_full,
    output logic   q_push,
    output event_t q_data
);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_M      = 8'h4D;

    // header match state; the first three equal the frame kinds
    localparam logic [1:0] HK_MISMATCH = 2'd0;
    localparam logic [1:0] HK_PRESENCE = 2'd1;
    localparam logic [1:0] HK_SPEED    = 2'd2;
    localparam logic [1:0] HK_MATCHING = 2'd3;

    // byte offsets from the dollar sign
    localparam logic [3:0] POS_TALKER0 = 4'd1;
    localparam logic [3:0] POS_TALKER1 = 4'd2;
    localparam logic [3:0] POS_TYPE    = 4'd3;
    localparam logic [3:0] POS_MID     = 4'd4;
    localparam logic [3:0] POS_LAST    = 4'd5;
    localparam logic [3:0] POS_STATUS  = 4'd7;
    localparam logic [3:0] POS_BODY    = 4'd8;
    localparam logic [2:0] HP_STOP     = 3'd7;
    localparam logic [2:0] HP_KIND_MIN = 3'd5;

    logic       in_frame_reg, in_frame_next;
    logic [2:0] hp_reg, hp_next;
    logic [1:0] hk_reg, hk_next;
    logic       pf_reg, pf_next;

    logic       accept;
    logic [7:0] c;
    logic       last;
    logic       is_end_char;
    logic [3:0] idx;
    logic [2:0] cls;
    logic [3:0] dig;
    logic [1:0] close_kind;

    assign s_ready     = !q_full;
    assign accept      = s_valid && !q_full;
    assign c           = s_data.rx_byte;
    assign last        = s_data.buffer_end;
    assign is_end_char = (c == CH_STAR) || (c == CH_CR) || (c == CH_LF);
    assign idx         = (hp_reg < HP_STOP) ? {1'b0, hp_reg} + 4'd1 : POS_BODY;

    // classify for the field parser
    always_comb begin
        dig = '0;
        if (c == CH_COMMA) begin
            cls = CC_COMMA;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            cls = CC_DIGIT;
            dig = 4'(c - CH_ZERO);
        end else if (c == CH_PLUS) begin
            cls = CC_PLUS;
        end else if (c == CH_MINUS) begin
            cls = CC_MINUS;
        end else if (c == CH_POINT) begin
            cls = CC_POINT;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
            cls = CC_SPACE;
        end else begin
            cls = CC_OTHER;
        end
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        hp_next       = hp_reg;
        hk_next       = hk_reg;
        pf_next       = pf_reg;
        q_push        = 1'b0;
        q_data.op     = OP_DATA;
        q_data.cls    = cls;
        q_data.dig    = dig;
        q_data.closes = 1'b0;

        if (accept) begin
            if (!in_frame_reg) begin
                if (c == CH_DOLLAR) begin
                    in_frame_next = !last;
                    hp_next       = '0;
                    hk_next       = HK_MATCHING;
                    pf_next       = 1'b0;
                    q_push        = 1'b1;
                    q_data.op     = OP_OPEN;
                    q_data.closes = last;
                end
            end else if (is_end_char) begin
                in_frame_next = 1'b0;
                q_push        = 1'b1;
                q_data.op     = OP_CLOSE;
                q_data.closes = 1'b1;
            end else begin
                if (hp_reg < HP_STOP) begin
                    hp_next = hp_reg + 3'd1;
                end
                case (idx)
                    POS_TALKER0: begin
                        if (hk_reg == HK_MATCHING && c != CH_D) hk_next = HK_MISMATCH;
                    end
                    POS_TALKER1: begin
                        if (hk_reg == HK_MATCHING && c != CH_F) hk_next = HK_MISMATCH;
                    end
                    POS_TYPE: begin
                        if (hk_reg == HK_MATCHING) begin
                            hk_next = (c == CH_H) ? HK_PRESENCE :
                                      (c == CH_D) ? HK_SPEED : HK_MISMATCH;
                        end
                    end
                    POS_MID: begin
                        if ((hk_reg == HK_PRESENCE && c != CH_P) ||
                            (hk_reg == HK_SPEED && c != CH_M)) begin
                            hk_next = HK_MISMATCH;
                        end
                    end
                    POS_LAST: begin
                        if (c != CH_D) hk_next = HK_MISMATCH;
                    end
                    POS_STATUS: begin
                        if (hk_reg == HK_PRESENCE && c == CH_ONE) pf_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
                in_frame_next = !last;
                q_push        = 1'b1;
                q_data.closes = last;
            end
        end

        // kind as it stands once this byte is taken
        close_kind = (hp_next >= HP_KIND_MIN && hk_next != HK_MATCHING) ? hk_next
                                                                          : KIND_UNKNOWN;
        q_data.kind    = close_kind;
        q_data.present = (close_kind == KIND_PRESENCE) ? pf_next : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            hp_reg       <= '0;
            hk_reg       <= HK_MISMATCH;
            pf_reg       <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            hp_reg       <= hp_next;
            hk_reg       <= hk_next;
            pf_reg       <= pf_next;
        end
    end

endmodule

[hw/rtl/rsp_back.sv]
`include "radar_sentence_parser_defines.svh"

module rsp_back
    import rsp_pkg::*;
#(
    parameter int MAX_PARTS = 10
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_empty,
    input  event_t q_data,
    output logic   q_pop,
    output logic   m_valid,
    input  logic   m_ready,
    output out_t   m_data
);

    // number parse phases
    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_INT   = 3'd1;
    localparam logic [2:0] PH_POINT = 3'd2;
    localparam logic [2:0] PH_FRAC2 = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam logic [PART_W-1:0] TOK_COUNT  = PART_W'(1);
    localparam logic [PART_W-1:0] TOK_RANGE  = PART_W'(3);
    localparam logic [PART_W-1:0] TOK_SPEED  = PART_W'(4);
    localparam logic [PART_W-1:0] TOK_ENERGY = PART_W'(5);
    localparam logic [PART_W-1:0] PARTS_MIN  = PART_W'(6);
    localparam logic [PART_W-1:0] PARTS_CAP  = PART_W'(MAX_PARTS);

    localparam logic [INT_W-1:0] INT_CAP = '1;

    logic [PART_W-1:0] pidx_reg, pidx_next;
    logic              has_reg, has_next;
    logic              pend_reg, pend_next;
    logic [1:0]        pend_kind_reg, pend_kind_next;
    logic              pend_present_reg, pend_present_next;
    logic [INT_W-1:0]  ip_reg, ip_next;
    logic              sign_reg, sign_next;
    logic [2:0]        ph_reg, ph_next;
    logic [6:0]        fr_reg, fr_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic [15:0]       rng_reg, rng_next;
    logic [15:0]       spd_reg, spd_next;
    logic [31:0]       nrg_reg, nrg_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic              slot_free;
    logic              end_req;
    logic              emit;
    logic [1:0]        emit_kind;
    logic              emit_present;
    logic              valid_out;

    logic [INT_W-1:0]  cur_ip;
    logic              cur_sign;
    logic [2:0]        cur_ph;
    logic [6:0]        cur_fr;
    logic [INT_W+3:0]  ip_x10;
    logic [6:0]        dig_x10;

    logic [INT_W+6:0]  mag;
    logic [16:0]       neg_mag;
    logic [16:0]       mag_clip;
    logic [7:0]        cnt_conv;
    logic [15:0]       rng_conv;
    logic [15:0]       spd_conv;
    logic [31:0]       nrg_conv;

    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // part values from the finished number
    always_comb begin
        mag = ({7'd0, ip_reg} << 6) + ({7'd0, ip_reg} << 5) + ({7'd0, ip_reg} << 2)
            + (INT_W + 7)'(fr_reg);
        cnt_conv = sign_reg ? 8'd0 : ((ip_reg > INT_W'(255)) ? 8'hFF : ip_reg[7:0]);
        rng_conv = sign_reg ? 16'd0 : ((mag > (INT_W + 7)'(65535)) ? 16'hFFFF : mag[15:0]);
        nrg_conv = sign_reg ? 32'd0 :
                   ((ip_reg > INT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ip_reg[31:0]);
        if (sign_reg) begin
            mag_clip = (mag > (INT_W + 7)'(32768)) ? 17'h08000 : mag[16:0];
        end else begin
            mag_clip = (mag > (INT_W + 7)'(32767)) ? 17'h07FFF : mag[16:0];
        end
        neg_mag  = 17'h10000 - mag_clip;
        spd_conv = sign_reg ? neg_mag[15:0] : mag_clip[15:0];
    end

    // number state as seen by the byte, cleared at a part's first character
    always_comb begin
        cur_ip   = has_reg ? ip_reg : '0;
        cur_sign = has_reg ? sign_reg : 1'b0;
        cur_ph   = has_reg ? ph_reg : PH_LEAD;
        cur_fr   = has_reg ? fr_reg : '0;
        ip_x10   = ({4'd0, cur_ip} << 3) + ({4'd0, cur_ip} << 1) + (INT_W + 4)'(q_data.dig);
        dig_x10  = ({3'd0, q_data.dig} << 3) + ({3'd0, q_data.dig} << 1);
    end

    always_comb begin
        pidx_next         = pidx_reg;
        has_next          = has_reg;
        pend_next         = pend_reg;
        pend_kind_next    = pend_kind_reg;
        pend_present_next = pend_present_reg;
        ip_next           = ip_reg;
        sign_next         = sign_reg;
        ph_next           = ph_reg;
        fr_next           = fr_reg;
        cnt_next          = cnt_reg;
        rng_next          = rng_reg;
        spd_next          = spd_reg;
        nrg_next          = nrg_reg;
        q_pop             = 1'b0;
        end_req           = 1'b0;
        emit              = 1'b0;
        emit_kind         = q_data.kind;
        emit_present      = q_data.present;

        if (pend_reg) begin
            // finish a close carried by its own data or open byte
            if (slot_free) begin
                end_req      = 1'b1;
                emit         = 1'b1;
                emit_kind    = pend_kind_reg;
                emit_present = pend_present_reg;
                pend_next    = 1'b0;
            end
        end else if (!q_empty && (q_data.op != OP_CLOSE || slot_free)) begin
            q_pop = 1'b1;
            case (q_data.op)
                OP_OPEN: begin
                    pidx_next = '0;
                    has_next  = 1'b1;
                    ip_next   = '0;
                    sign_next = 1'b0;
                    ph_next   = PH_LEAD;
                    fr_next   = '0;
                end
                OP_DATA: begin
                    if (q_data.cls == CC_COMMA) begin
                        end_req = 1'b1;
                    end else begin
                        has_next  = 1'b1;
                        ip_next   = cur_ip;
                        sign_next = cur_sign;
                        ph_next   = cur_ph;
                        fr_next   = cur_fr;
                        case (cur_ph)
                            PH_LEAD: begin
                                if (q_data.cls == CC_PLUS || q_data.cls == CC_MINUS) begin
                                    sign_next = (q_data.cls == CC_MINUS);
                                    ph_next   = PH_INT;
                                end else if (q_data.cls == CC_DIGIT) begin
                                    ip_next = INT_W'(q_data.dig);
                                    ph_next = PH_INT;
                                end else if (q_data.cls == CC_POINT) begin
                                    ph_next = PH_POINT;
                                end else if (q_data.cls != CC_SPACE) begin
                                    ph_next = PH_DONE;
                                end
                            end
                            PH_INT: begin
                                if (q_data.cls == CC_DIGIT) begin
                                    ip_next = (ip_x10 > {4'd0, INT_CAP}) ? INT_CAP
                                                                         : ip_x10[INT_W-1:0];
                                end else if (q_data.cls == CC_POINT) begin
                                    ph_next = PH_POINT;
                                end else begin
                                    ph_next = PH_DONE;
                                end
                            end
                            PH_POINT: begin
                                if (q_data.cls == CC_DIGIT) begin
                                    fr_next = dig_x10;
                                    ph_next = PH_FRAC2;
                                end else begin
                                    ph_next = PH_DONE;
                                end
                            end
                            PH_FRAC2: begin
                                if (q_data.cls == CC_DIGIT) begin
                                    fr_next = cur_fr + 7'(q_data.dig);
                                end
                                ph_next = PH_DONE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                OP_CLOSE: begin
                    end_req = 1'b1;
                    emit    = 1'b1;
                end
                default: begin
                end
            endcase
            if (q_data.closes && q_data.op != OP_CLOSE) begin
                pend_next         = 1'b1;
                pend_kind_next    = q_data.kind;
                pend_present_next = q_data.present;
            end
        end

        // end of a part: store it if it had characters
        if (end_req && has_reg) begin
            has_next = 1'b0;
            if (pidx_reg < PARTS_CAP) begin
                pidx_next = pidx_reg + 1'b1;
            end
            case (pidx_reg)
                TOK_COUNT:  cnt_next = cnt_conv;
                TOK_RANGE:  rng_next = rng_conv;
                TOK_SPEED:  spd_next = spd_conv;
                TOK_ENERGY: nrg_next = nrg_conv;
                default: begin
                end
            endcase
        end

        valid_out                  = (emit_kind == KIND_SPEED) && (pidx_next >= PARTS_MIN);
        m_data_next                = m_data_reg;
        m_valid_next               = m_valid_reg && !m_ready;
        if (emit) begin
            m_valid_next                = 1'b1;
            m_data_next.frame_kind      = emit_kind;
            m_data_next.target_present  = emit_present;
            m_data_next.fields_valid    = valid_out;
            m_data_next.target_count    = valid_out ? cnt_next : 8'd0;
            m_data_next.range_cm        = valid_out ? rng_next : 16'd0;
            m_data_next.speed_cm_per_s  = valid_out ? $signed(spd_next) : 16'sd0;
            m_data_next.energy_value    = valid_out ? nrg_next : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pidx_reg    <= '0;
            has_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            sign_reg    <= 1'b0;
            ph_reg      <= PH_LEAD;
            m_valid_reg <= 1'b0;
        end else begin
            pidx_reg    <= pidx_next;
            has_reg     <= has_next;
            pend_reg    <= pend_next;
            sign_reg    <= sign_next;
            ph_reg      <= ph_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_kind_reg    <= pend_kind_next;
        pend_present_reg <= pend_present_next;
        ip_reg           <= ip_next;
        fr_reg           <= fr_next;
        cnt_reg          <= cnt_next;
        rng_reg          <= rng_next;
        spd_reg          <= spd_next;
        nrg_reg          <= nrg_next;
        m_data_reg       <= m_data_next;
    end

    `RSP_ASSERT_IMPLIES(a_pend_blocks_pop, aclk, aresetn, pend_reg, !q_pop)
    `RSP_ASSERT_NEXT(a_close_emits, aclk, aresetn, q_pop && q_data.op == OP_CLOSE, m_valid_reg)
    `RSP_ASSERT_IMPLIES(a_fields_speed_only, aclk, aresetn, m_valid_reg && m_data_reg.fields_valid, m_data_reg.frame_kind == KIND_SPEED)
    `RSP_ASSERT_IMPLIES(a_present_kind, aclk, aresetn, m_valid_reg && m_data_reg.target_present, m_data_reg.frame_kind == KIND_PRESENCE)

endmodule

[hw/rtl/radar_sentence_parser.sv]
// Sentence parser for a radar module's ASCII stream: takes one received byte
// per cycle on s_, and for every frame that opens at '$' and closes at '*',
// CR, LF or a byte flagged buffer_end, delivers one decoded word on m_
// (header kind, presence status, and target count, range, speed and energy
// of a speed sentence). The front end matches the header and classifies
// each byte in the cycle it is taken; a QUEUE_DEPTH-word queue hands the
// bytes to the field parser, which converts numbers and holds the result
// in an output register. A byte is taken every cycle as long as the queue
// has room; the field parser drains one word per cycle, except that a
// buffer_end byte that carries data or opens a frame leaves a close pending
// that is finished before the next word is drained, and it stalls only
// while a finished result waits on m_ready. A result is written to the
// output register as the close word or the pending close is handled.
module radar_sentence_parser
    import rsp_pkg::*;
#(
    parameter int MAX_PARTS   = 10,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    event_t q_wdata;
    event_t q_rdata;

    rsp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    rsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    rsp_back #(
        .MAX_PARTS (MAX_PARTS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
